// ----- hw/rtl/kdlp_pkg.sv -----
// Shared types and constants for the key debouncer with long press and auto-repeat.
`default_nettype none
package kdlp_pkg;

  // Event codes on event_kind
  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_LONG    = 2'd2
  } kind_t;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT        = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_POLARITY   = 4'd3;

  // Register reset values
  localparam logic [15:0] LONG_PRESS_RST = 16'd500;
  localparam logic [7:0]  REPEAT_RST     = 8'd10;
  localparam logic [4:0]  KEY_COUNT_RST  = 5'd5;
  localparam logic [15:0] POLARITY_RST   = 16'hFFFF;

  // Events found by one lane in one tick: slot a is press/release,
  // slot b is long or repeat press and always follows slot a.
  typedef struct packed {
    logic  a_vld;
    kind_t a_kind;
    logic  b_vld;
    kind_t b_kind;
  } lane_ev_t;

  // Serializer status
  typedef struct packed {
    logic busy;
    logic pend_any;
  } merge_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/kdlp_lane.sv -----
// One key lane: hysteresis filter, key state, hold and repeat counters.
`default_nettype none
module kdlp_lane #(
  parameter int FILTER_TICKS = 5
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            pressed,
  input  wire logic [15:0]     long_press_ticks,
  input  wire logic [7:0]      repeat_period,
  output kdlp_pkg::lane_ev_t   ev
);

  localparam logic [3:0] F_MID  = 4'(FILTER_TICKS);
  localparam logic [3:0] F_TOP  = 4'(2 * FILTER_TICKS);
  localparam logic [3:0] F_INIT = 4'(FILTER_TICKS / 2);

  logic [3:0]  filt;
  logic [3:0]  filt_next;
  logic        down;
  logic        down_next;
  logic [15:0] hold;
  logic [15:0] hold_next;
  logic [7:0]  rep;
  logic [7:0]  rep_next;
  logic [15:0] hold_inc;
  logic [7:0]  rep_inc;

  assign hold_inc = hold + 16'd1;
  assign rep_inc  = rep + 8'd1;

  always_comb begin
    filt_next = filt;
    down_next = down;
    hold_next = hold;
    rep_next  = rep;
    ev        = '0;
    ev.a_kind = kdlp_pkg::KIND_PRESS;
    ev.b_kind = kdlp_pkg::KIND_PRESS;
    if (pressed) begin
      if (filt < F_MID) begin
        filt_next = F_MID;
      end else if (filt < F_TOP) begin
        filt_next = filt + 4'd1;
      end else begin
        if (!down) begin
          down_next = 1'b1;
          ev.a_vld  = 1'b1;
        end
        if (long_press_ticks != 16'd0) begin
          if (hold < long_press_ticks) begin
            hold_next = hold_inc;
            if (hold_inc == long_press_ticks) begin
              ev.b_vld  = 1'b1;
              ev.b_kind = kdlp_pkg::KIND_LONG;
            end
          end else if (repeat_period != 8'd0) begin
            if (rep_inc >= repeat_period) begin
              rep_next = 8'd0;
              ev.b_vld = 1'b1;
            end else begin
              rep_next = rep_inc;
            end
          end
        end
      end
    end else begin
      if (filt > F_MID) begin
        filt_next = F_MID;
      end else if (filt != 4'd0) begin
        filt_next = filt - 4'd1;
      end else if (down) begin
        down_next = 1'b0;
        ev.a_vld  = 1'b1;
        ev.a_kind = kdlp_pkg::KIND_RELEASE;
      end
      hold_next = 16'd0;
      rep_next  = 8'd0;
    end
    // events count only for a scanned key on an accepted tick
    ev.a_vld = ev.a_vld & en;
    ev.b_vld = ev.b_vld & en;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filt <= F_INIT;
      down <= 1'b0;
      hold <= 16'd0;
      rep  <= 8'd0;
    end else if (en) begin
      filt <= filt_next;
      down <= down_next;
      hold <= hold_next;
      rep  <= rep_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/kdlp_merge.sv -----
// Event merge: captures the lanes' event slots and sends them out one at a time in slot order.
`default_nettype none
module kdlp_merge #(
  parameter int NUM_KEYS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire logic [2*NUM_KEYS-1:0] slot_ev,
  input  wire kdlp_pkg::kind_t       slot_kind [2*NUM_KEYS],
  input  wire logic                  event_stall,
  output logic                       event_valid,
  output logic [3:0]                 event_key,
  output logic [1:0]                 event_kind,
  output logic                       last_event,
  output kdlp_pkg::merge_status_t    status
);

  localparam int NSLOT = 2 * NUM_KEYS;
  localparam int IW    = $clog2(NSLOT);

  logic [NSLOT-1:0] pend;
  kdlp_pkg::kind_t  kinds [NSLOT];
  logic [IW-1:0]    idx;
  logic             busy;
  logic             out_free;
  logic             take;
  logic [NSLOT-1:0] rest;

  assign out_free = !event_valid || !event_stall;
  assign take     = busy && pend[idx] && out_free;
  assign rest     = pend & ~(NSLOT'(1) << idx);

  assign status.busy     = busy;
  assign status.pend_any = |pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      idx  <= '0;
      busy <= 1'b0;
    end else if (load) begin
      pend <= slot_ev;
      idx  <= '0;
      busy <= |slot_ev;
    end else if (busy) begin
      if (!pend[idx]) begin
        idx <= idx + IW'(1);
      end else if (out_free) begin
        pend <= rest;
        idx  <= idx + IW'(1);
        busy <= |rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kinds <= slot_kind;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (take) begin
      event_valid <= 1'b1;
    end else if (!event_stall) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      event_key  <= 4'(idx >> 1);
      event_kind <= kinds[idx];
      last_event <= (rest == '0);
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/key_debounce_long_press_repeat.sv -----
// Top level of the key debouncer with long press and auto-repeat.
`default_nettype none
// Each accepted transfer on the tick channel is one scan tick of raw pin
// levels. All scanned keys are filtered in parallel lanes in the cycle the
// tick is accepted; the events found are then sent out in key order, press
// or release before long or repeat press for the same key, with last_event
// set on the final event of the tick. A tick with events holds tick_stall
// high while the serializer walks its event slots in order up to the last
// pending one, one slot per cycle unless event_stall holds the output
// register while a pending slot waits. The output register lets the next
// tick be accepted while the final event of the previous one still waits.
// Registers are written through the cfg channel (always ready); write only
// while no events are pending.
module key_debounce_long_press_repeat #(
  parameter int NUM_KEYS     = 16,
  parameter int FILTER_TICKS = 5
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // scan ticks
  input  wire logic                           tick_valid,
  output logic                                tick_stall,
  input  wire logic [15:0]                    pin_levels,
  // events
  output logic                                event_valid,
  input  wire logic                           event_stall,
  output logic [3:0]                          event_key,
  output logic [1:0]                          event_kind,
  output logic                                last_event,
  // configuration writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [kdlp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kdlp_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int NSLOT = 2 * NUM_KEYS;

  logic [15:0] long_press_ticks;
  logic [7:0]  repeat_period;
  logic [4:0]  key_count;
  logic [15:0] press_polarity;
  logic [4:0]  count_eff;
  logic        tick_xfer;

  kdlp_pkg::lane_ev_t      lane_ev [NUM_KEYS];
  logic [NSLOT-1:0]        slot_ev;
  kdlp_pkg::kind_t         slot_kind [NSLOT];
  kdlp_pkg::merge_status_t mstat;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= kdlp_pkg::LONG_PRESS_RST;
      repeat_period    <= kdlp_pkg::REPEAT_RST;
      key_count        <= kdlp_pkg::KEY_COUNT_RST;
      press_polarity   <= kdlp_pkg::POLARITY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        kdlp_pkg::REG_LONG_PRESS_TICKS: long_press_ticks <= cfg_data;
        kdlp_pkg::REG_REPEAT_PERIOD:    repeat_period    <= cfg_data[7:0];
        kdlp_pkg::REG_KEY_COUNT:        key_count        <= cfg_data[4:0];
        kdlp_pkg::REG_PRESS_POLARITY:   press_polarity   <= cfg_data;
        default: ;
      endcase
    end
  end

  // key counts above the lane count clamp to it
  assign count_eff = (key_count > 5'(NUM_KEYS)) ? 5'(NUM_KEYS) : key_count;

  // one tick at a time: stalled while the serializer still has slots
  assign tick_stall = mstat.busy;
  assign tick_xfer  = tick_valid && !tick_stall;

  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_lane
    kdlp_lane #(
      .FILTER_TICKS(FILTER_TICKS)
    ) u_lane (
      .clk              (clk),
      .rst              (rst),
      .en               (tick_xfer && (5'(i) < count_eff)),
      .pressed          (pin_levels[i] != press_polarity[i]),
      .long_press_ticks (long_press_ticks),
      .repeat_period    (repeat_period),
      .ev               (lane_ev[i])
    );

    // slot 2i: press/release, slot 2i+1: long or repeat press
    assign slot_ev[2*i]     = lane_ev[i].a_vld;
    assign slot_ev[2*i+1]   = lane_ev[i].b_vld;
    assign slot_kind[2*i]   = lane_ev[i].a_kind;
    assign slot_kind[2*i+1] = lane_ev[i].b_kind;
  end

  kdlp_merge #(
    .NUM_KEYS(NUM_KEYS)
  ) u_merge (
    .clk         (clk),
    .rst         (rst),
    .load        (tick_xfer),
    .slot_ev     (slot_ev),
    .slot_kind   (slot_kind),
    .event_stall (event_stall),
    .event_valid (event_valid),
    .event_key   (event_key),
    .event_kind  (event_kind),
    .last_event  (last_event),
    .status      (mstat)
  );

  // serializer never sits idle with slots still pending
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !mstat.busy |-> !mstat.pend_any)
    else $error("pending event slots while serializer idle");

  // events only name scanned keys
  a_key_range: assert property (@(posedge clk) disable iff (rst)
    event_valid |-> ({1'b0, event_key} < count_eff))
    else $error("event for an unscanned key");

  // only defined event codes leave the block
  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    event_valid |-> (event_kind == kdlp_pkg::KIND_PRESS ||
                     event_kind == kdlp_pkg::KIND_RELEASE ||
                     event_kind == kdlp_pkg::KIND_LONG))
    else $error("undefined event kind");

  // an accepted tick with events keeps the tick channel stalled next cycle
  a_busy_after_load: assert property (@(posedge clk) disable iff (rst)
    (tick_xfer && (slot_ev != '0)) |=> tick_stall)
    else $error("tick channel open with events pending");

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the key debouncer with long press and auto-repeat.
`timescale 1ns / 1ps

module tb;

  localparam int NKEYS        = 16;
  localparam int FILTER_TICKS = 5;
  // filter thresholds at the width of the per-key counter
  localparam logic [3:0] FILT_MID = 4'(FILTER_TICKS);
  localparam logic [3:0] FILT_TOP = 4'(2 * FILTER_TICKS);
  localparam logic [3:0] FILT_RST = 4'(FILTER_TICKS / 2);
  // indexes past the last register; writes there must change nothing
  localparam logic [kdlp_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO =
    kdlp_pkg::REG_PRESS_POLARITY + 1'b1;
  localparam logic [kdlp_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

  localparam int RANDOM_TICKS   = 440;
  localparam int TAIL_TICKS     = 60;             // final stretch runs with no idling
  localparam int DRAIN_CYCLES   = 2 * NKEYS + 8;  // full slot walk plus margin
  localparam int WATCHDOG_LIMIT = 2000;           // cycles with no transfer at all
  localparam int MAX_REPORTS    = 40;

  logic                            clk;
  logic                            rst;
  logic                            tick_valid;
  logic                            tick_stall;
  logic [15:0]                     pin_levels;
  logic                            event_valid;
  logic                            event_stall;
  logic [3:0]                      event_key;
  logic [1:0]                      event_kind;
  logic                            last_event;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [kdlp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [kdlp_pkg::CFG_DATA_W-1:0] cfg_data;

  // One event as it should leave the block.
  typedef struct packed {
    logic [3:0]      key;
    kdlp_pkg::kind_t kind;
    logic            last;
  } key_event_t;

  // Directed script row: a register write or one scan tick. For a tick,
  // n_typed >= 0 means the events are spelled out here (keys 0..n_typed-1,
  // all of one kind); -1 means the predictor supplies them.
  typedef struct packed {
    logic                            is_write;
    logic [kdlp_pkg::CFG_IDX_W-1:0]  idx;
    logic [kdlp_pkg::CFG_DATA_W-1:0] data;   // register value, or pin levels for a tick
    int                              n_typed;
    kdlp_pkg::kind_t                 kind;
  } script_row_t;

  key_event_t pending_events[$];  // events still owed by the block, oldest first
  key_event_t tick_events[$];     // events found for the tick being predicted

  // Predictor copy of the registers and of the per-key state.
  logic [15:0] long_ticks;
  logic [7:0]  rep_period;
  logic [4:0]  keys_used;
  logic [15:0] polarity;
  logic [3:0]  filt_cnt [NKEYS];
  logic        key_held [NKEYS];
  logic [15:0] hold_cnt [NKEYS];
  logic [7:0]  rep_cnt  [NKEYS];

  int mismatches  = 0;
  bit steady_tail = 1'b0;  // set for the last part of the run: no idling on either side

  key_debounce_long_press_repeat #(
    .NUM_KEYS     (NKEYS),
    .FILTER_TICKS (FILTER_TICKS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .tick_valid  (tick_valid),
    .tick_stall  (tick_stall),
    .pin_levels  (pin_levels),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_key   (event_key),
    .event_kind  (event_kind),
    .last_event  (last_event),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin : clock_gen
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  function automatic void add_event(input int k, input kdlp_pkg::kind_t kind);
    key_event_t ev;
    ev.key  = 4'(k);
    ev.kind = kind;
    ev.last = 1'b0;
    tick_events.push_back(ev);
  endfunction

  function automatic script_row_t tick_row(input logic [15:0] pins, input int n_typed = -1,
                                           input kdlp_pkg::kind_t kind = kdlp_pkg::KIND_PRESS);
    script_row_t row;
    row.is_write = 1'b0;
    row.idx      = kdlp_pkg::REG_LONG_PRESS_TICKS;
    row.data     = pins;
    row.n_typed  = n_typed;
    row.kind     = kind;
    return row;
  endfunction

  function automatic script_row_t reg_row(input logic [kdlp_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [kdlp_pkg::CFG_DATA_W-1:0] val);
    script_row_t row;
    row.is_write = 1'b1;
    row.idx      = idx;
    row.data     = val;
    row.n_typed  = -1;
    row.kind     = kdlp_pkg::KIND_PRESS;
    return row;
  endfunction

  // Register write as the block sees it: fields narrower than the data bus
  // keep only their low bits, unknown indexes are dropped.
  task automatic apply_reg(input logic [kdlp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [kdlp_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      kdlp_pkg::REG_LONG_PRESS_TICKS: long_ticks = val;
      kdlp_pkg::REG_REPEAT_PERIOD:    rep_period = val[7:0];
      kdlp_pkg::REG_KEY_COUNT:        keys_used  = val[4:0];
      kdlp_pkg::REG_PRESS_POLARITY:   polarity   = val;
      default: ;
    endcase
  endtask

  // One scan tick through the debouncer: fills tick_events in key order.
  task automatic debounce_tick(input logic [15:0] pins);
    int scanned;
    tick_events.delete();
    // counts above the number of keys scan all keys; the rest keep their state
    scanned = (keys_used > 5'(NKEYS)) ? NKEYS : int'(keys_used);
    for (int k = 0; k < scanned; k++) begin
      if (pins[k] != polarity[k]) begin
        // pressed: jump to the midpoint, climb to the top, then act
        if (filt_cnt[k] < FILT_MID) begin
          filt_cnt[k] = FILT_MID;
        end else if (filt_cnt[k] < FILT_TOP) begin
          filt_cnt[k] = filt_cnt[k] + 4'd1;
        end else begin
          if (!key_held[k]) begin
            key_held[k] = 1'b1;
            add_event(k, kdlp_pkg::KIND_PRESS);
          end
          if (long_ticks != 16'd0) begin
            if (hold_cnt[k] < long_ticks) begin
              hold_cnt[k] = hold_cnt[k] + 16'd1;
              if (hold_cnt[k] == long_ticks) add_event(k, kdlp_pkg::KIND_LONG);
            end else if (rep_period != 8'd0) begin
              // a count left above a lowered period fires on this increment
              rep_cnt[k] = rep_cnt[k] + 8'd1;
              if (rep_cnt[k] >= rep_period) begin
                rep_cnt[k] = 8'd0;
                add_event(k, kdlp_pkg::KIND_PRESS);
              end
            end
          end
        end
      end else begin
        // released: snap to the midpoint, count down, release at zero
        if (filt_cnt[k] > FILT_MID) begin
          filt_cnt[k] = FILT_MID;
        end else if (filt_cnt[k] != 4'd0) begin
          filt_cnt[k] = filt_cnt[k] - 4'd1;
        end else if (key_held[k]) begin
          key_held[k] = 1'b0;
          add_event(k, kdlp_pkg::KIND_RELEASE);
        end
        hold_cnt[k] = 16'd0;
        rep_cnt[k]  = 8'd0;
      end
    end
  endtask

  // Called at a falling edge; leaves cfg_valid high so back-to-back writes
  // never lower and raise it in the same step.
  task automatic write_reg(input logic [kdlp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [kdlp_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
    @(negedge clk);
  endtask

  // Offer one tick, wait for the transfer, then queue what it should cause.
  // Called at a falling edge and returns at one; tick_valid stays high unless
  // a gap is taken, so consecutive ticks stream without a drop.
  task automatic send_tick(input logic [15:0] pins, input int n_typed,
                           input kdlp_pkg::kind_t kind);
    if (cfg_valid) cfg_valid <= 1'b0;
    if (!steady_tail && $urandom_range(0, 3) == 0) begin
      tick_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    tick_valid <= 1'b1;
    pin_levels <= pins;
    @(posedge clk);
    while (tick_stall) @(posedge clk);
    // predictor always runs so its state tracks the block
    debounce_tick(pins);
    if (n_typed >= 0) begin
      tick_events.delete();
      for (int k = 0; k < n_typed; k++) add_event(k, kind);
    end
    if (tick_events.size() > 0) tick_events[tick_events.size() - 1].last = 1'b1;
    foreach (tick_events[j]) pending_events.push_back(tick_events[j]);
    @(negedge clk);
  endtask

  // Stop offering ticks and let the block go idle. Ticks with no events leave
  // nothing in the queue, so a full slot walk is allowed after it empties.
  task automatic drain_events();
    tick_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Settings for one random phase. The first two pin the extremes; later ones
  // favor short hold times so long presses and repeats actually happen.
  // Upper data bits above each narrow field carry junk that must be dropped.
  task automatic program_phase(input int phase);
    logic [15:0] lp;
    logic [7:0]  rp;
    logic [4:0]  kc;
    logic [15:0] pol;
    logic [15:0] junk;
    junk = 16'($urandom);
    case (phase)
      0: begin
        lp = 16'hFFFF; rp = 8'hFF; kc = 5'(NKEYS); pol = 16'($urandom);
      end
      1: begin
        lp = 16'd0; rp = 8'd0; kc = 5'(NKEYS); pol = 16'($urandom);
      end
      default: begin
        case ($urandom_range(0, 9))
          0:       lp = 16'd0;
          1:       lp = 16'd1;
          2:       lp = 16'hFFFF;
          3:       lp = 16'($urandom);
          default: lp = 16'($urandom_range(2, 20));
        endcase
        case ($urandom_range(0, 9))
          0:       rp = 8'd0;
          1:       rp = 8'd1;
          2:       rp = 8'hFF;
          3:       rp = 8'($urandom);
          default: rp = 8'($urandom_range(2, 6));
        endcase
        case ($urandom_range(0, 9))
          0:       kc = 5'd0;
          1:       kc = 5'($urandom_range(NKEYS + 1, 31));
          2, 3:    kc = 5'($urandom_range(1, NKEYS - 1));
          default: kc = 5'(NKEYS);
        endcase
        case ($urandom_range(0, 5))
          0:       pol = 16'h0000;
          1:       pol = 16'hFFFF;
          default: pol = 16'($urandom);
        endcase
      end
    endcase
    write_reg(kdlp_pkg::REG_LONG_PRESS_TICKS, lp);
    write_reg(kdlp_pkg::REG_REPEAT_PERIOD, {junk[15:8], rp});
    write_reg(kdlp_pkg::REG_KEY_COUNT, {junk[15:5], kc});
    write_reg(kdlp_pkg::REG_PRESS_POLARITY, pol);
    if ($urandom_range(0, 3) == 0)
      write_reg(kdlp_pkg::CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                16'($urandom));
  endtask

  // Every event transfer is compared with the oldest one owed.
  always @(posedge clk) begin : check_events
    key_event_t want;
    if (!rst && event_valid === 1'b1 && !event_stall) begin
      if (pending_events.size() == 0) begin
        note_mismatch($sformatf("event key %0d kind %0d with none expected",
                                event_key, event_kind));
      end else begin
        want = pending_events.pop_front();
        if (event_key !== want.key)
          note_mismatch($sformatf("event_key %0d, expected %0d", event_key, want.key));
        if (event_kind !== want.kind)
          note_mismatch($sformatf("event_kind %0d on key %0d, expected %0d",
                                  event_kind, want.key, want.kind));
        if (last_event !== want.last)
          note_mismatch($sformatf("last_event %0b on key %0d, expected %0b",
                                  last_event, want.key, want.last));
      end
    end
  end

  // Receiver back-pressure: short stall bursts, with calm stretches between.
  initial begin : event_stall_gen
    event_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!steady_tail) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            event_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(negedge clk);
            event_stall <= 1'b0;
          end
          2: repeat ($urandom_range(8, 30)) @(negedge clk);
          default: ;
        endcase
      end
    end
  end

  // Ends a hung run: counts cycles in which no channel moves a transfer.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((tick_valid && !tick_stall) || (event_valid && !event_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb failed");
    $finish;
  end

  initial begin : main_seq
    script_row_t script[$];
    script_row_t row;
    bit          dirty;
    int          sent;
    int          phase;
    int          phase_len;
    int          run_left;
    int          b;
    logic [15:0] pat;
    logic [15:0] pins;

    rst        = 1'b1;
    tick_valid = 1'b0;
    pin_levels = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;

    // predictor reset state
    long_ticks = kdlp_pkg::LONG_PRESS_RST;
    rep_period = kdlp_pkg::REPEAT_RST;
    keys_used  = kdlp_pkg::KEY_COUNT_RST;
    polarity   = kdlp_pkg::POLARITY_RST;
    for (int k = 0; k < NKEYS; k++) begin
      filt_cnt[k] = FILT_RST;
      key_held[k] = 1'b0;
      hold_cnt[k] = '0;
      rep_cnt[k]  = '0;
    end

    // Directed part, reset settings first: five keys, pressed when low.
    // All low: the filter climbs for six ticks, keys 0..4 press on the seventh.
    for (int i = 0; i < 6; i++) script.push_back(tick_row(16'h0000, 0));
    script.push_back(tick_row(16'h0000, 5, kdlp_pkg::KIND_PRESS));
    // All high: snap to midpoint, count down to zero, keys 0..4 release.
    for (int i = 0; i < 6; i++) script.push_back(tick_row(16'hFFFF, 0));
    script.push_back(tick_row(16'hFFFF, 5, kdlp_pkg::KIND_RELEASE));
    // Shortest hold and repeat on all sixteen keys, pressed when high. The
    // repeat write carries junk above its 8 bits; the unused index is ignored.
    script.push_back(reg_row(kdlp_pkg::REG_LONG_PRESS_TICKS, 16'd1));
    script.push_back(reg_row(kdlp_pkg::REG_REPEAT_PERIOD, 16'hFF01));
    script.push_back(reg_row(kdlp_pkg::REG_KEY_COUNT, 16'(NKEYS)));
    script.push_back(reg_row(kdlp_pkg::REG_PRESS_POLARITY, 16'h0000));
    script.push_back(reg_row(REG_UNUSED_HI, 16'hFFFF));
    for (int i = 0; i < 6; i++) script.push_back(tick_row(16'hFFFF, 0));
    // press and long together for every key: the full 32-event budget
    script.push_back(tick_row(16'hFFFF));
    // period of one: each key repeats on the very next tick
    script.push_back(tick_row(16'hFFFF, NKEYS, kdlp_pkg::KIND_PRESS));
    // Count above the key total, and the hold time raised mid-hold: the
    // counters carry on and the long event comes two ticks later.
    script.push_back(reg_row(kdlp_pkg::REG_KEY_COUNT, 16'd31));
    script.push_back(reg_row(kdlp_pkg::REG_LONG_PRESS_TICKS, 16'd3));
    script.push_back(tick_row(16'hFFFF));
    script.push_back(tick_row(16'hFFFF));
    script.push_back(tick_row(16'h0000));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    dirty = 1'b0;
    foreach (script[i]) begin
      row = script[i];
      if (row.is_write) begin
        // registers only change once the block has gone quiet
        if (dirty) begin
          drain_events();
          dirty = 1'b0;
        end
        write_reg(row.idx, row.data);
      end else begin
        send_tick(row.data, row.n_typed, row.kind);
        dirty = 1'b1;
      end
    end
    drain_events();

    // Random part: a pattern is held for a run of ticks, as a real key would
    // be, with the odd flipped bit for contact bounce. Runs and key state
    // carry over phase changes, so settings change in the middle of holds.
    sent     = 0;
    phase    = 0;
    run_left = 0;
    pat      = '0;
    while (sent < RANDOM_TICKS) begin
      program_phase(phase);
      phase_len = $urandom_range(40, 60);
      for (int j = 0; j < phase_len && sent < RANDOM_TICKS; j++) begin
        if (run_left == 0) begin
          case ($urandom_range(0, 3))
            0:       pat = ~polarity;        // every key pressed
            1:       pat = polarity;         // every key released
            default: pat = 16'($urandom);
          endcase
          run_left = $urandom_range(1, 40);
        end
        pins = pat;
        if ($urandom_range(0, 5) == 0) begin
          b = $urandom_range(0, NKEYS - 1);
          pins[b] = ~pins[b];
        end
        run_left--;
        steady_tail = (sent >= RANDOM_TICKS - TAIL_TICKS);
        send_tick(pins, -1, kdlp_pkg::KIND_PRESS);
        sent++;
      end
      drain_events();
      phase++;
    end

    if (mismatches == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/kdlp_pkg.sv
hw/rtl/kdlp_lane.sv
hw/rtl/kdlp_merge.sv
hw/rtl/key_debounce_long_press_repeat.sv
dv/tb.sv
